>>> sv/drt_pkg.sv
`timescale 1ns / 1ps

package drt_pkg;

	// Width of the stored bounds and of the clipped coordinates
	localparam int BoundWidth = 14;
	// Width of the reported box origin
	localparam int OrgWidth = 13;
	// Largest usable resolution; larger register values saturate here
	localparam logic [BoundWidth-1:0] MaxRes = 14'd8192;

	// Default width of the incoming rectangle fields
	localparam int DefCoordWidth = 16;

	// Configuration port
	localparam int CfgIdxWidth = 1;
	localparam int CfgDataWidth = 14;
	localparam logic [CfgIdxWidth-1:0] REG_SCREEN_WIDTH = 1'd0;
	localparam logic [CfgIdxWidth-1:0] REG_SCREEN_HEIGHT = 1'd1;

	localparam logic [CfgDataWidth-1:0] ResetScreenWidth = 14'd1024;
	localparam logic [CfgDataWidth-1:0] ResetScreenHeight = 14'd768;

	// Action codes
	localparam logic ACT_MARK = 1'b0;
	localparam logic ACT_TAKE = 1'b1;

	// Clipped rectangle handed from the clip logic to the bounds tracker
	typedef struct packed {
		logic                  keep;
		logic [BoundWidth-1:0] x;
		logic [BoundWidth-1:0] y;
		logic [BoundWidth-1:0] xe;
		logic [BoundWidth-1:0] ye;
	} drt_rect_t;

	// Box as reported on a take
	typedef struct packed {
		logic                  has;
		logic [OrgWidth-1:0]   x;
		logic [OrgWidth-1:0]   y;
		logic [BoundWidth-1:0] w;
		logic [BoundWidth-1:0] h;
	} drt_box_t;

endpackage

>>> sv/drt_if.sv
`timescale 1ns / 1ps

// Request channel: one mark or take word
interface drt_req_if #(
	parameter int COORD_WIDTH = 16
);
	logic                   valid;
	logic                   ready;
	logic                   action;
	logic [COORD_WIDTH-1:0] rect_x;
	logic [COORD_WIDTH-1:0] rect_y;
	logic [COORD_WIDTH-1:0] rect_w;
	logic [COORD_WIDTH-1:0] rect_h;

	modport source (output valid, action, rect_x, rect_y, rect_w, rect_h, input ready);
	modport sink (input valid, action, rect_x, rect_y, rect_w, rect_h, output ready);
endinterface

// Response channel: one box word per take
interface drt_rsp_if;
	logic        valid;
	logic        ready;
	logic        has_region;
	logic [12:0] box_x;
	logic [12:0] box_y;
	logic [13:0] box_w;
	logic [13:0] box_h;

	modport source (output valid, has_region, box_x, box_y, box_w, box_h, input ready);
	modport sink (input valid, has_region, box_x, box_y, box_w, box_h, output ready);
endinterface

>>> sv/drt_clip.sv
`timescale 1ns / 1ps

module drt_clip
	import drt_pkg::*;
#(
	parameter int COORD_WIDTH = DefCoordWidth
) (
	input  logic [CfgDataWidth-1:0] screen_width,
	input  logic [CfgDataWidth-1:0] screen_height,
	input  logic [COORD_WIDTH-1:0]  rect_x,
	input  logic [COORD_WIDTH-1:0]  rect_y,
	input  logic [COORD_WIDTH-1:0]  rect_w,
	input  logic [COORD_WIDTH-1:0]  rect_h,
	output drt_rect_t               rect
);

	logic [BoundWidth-1:0]  xres;
	logic [BoundWidth-1:0]  yres;
	logic [COORD_WIDTH:0]   xe_full;
	logic [COORD_WIDTH:0]   ye_full;

	// Saturate the resolution
	assign xres = (screen_width > MaxRes) ? MaxRes : screen_width;
	assign yres = (screen_height > MaxRes) ? MaxRes : screen_height;

	// End edges without wrap
	assign xe_full = {1'b0, rect_x} + {1'b0, rect_w};
	assign ye_full = {1'b0, rect_y} + {1'b0, rect_h};

	// Drop empty rectangles and those starting off screen; clip the far edges
	always_comb begin
		rect.keep = (rect_w != '0) && (rect_h != '0) &&
			(rect_x < COORD_WIDTH'(xres)) && (rect_y < COORD_WIDTH'(yres));
		rect.x = rect_x[BoundWidth-1:0];
		rect.y = rect_y[BoundWidth-1:0];
		rect.xe = (xe_full > (COORD_WIDTH+1)'(xres)) ? xres : xe_full[BoundWidth-1:0];
		rect.ye = (ye_full > (COORD_WIDTH+1)'(yres)) ? yres : ye_full[BoundWidth-1:0];
	end

endmodule

>>> sv/drt_bounds.sv
`timescale 1ns / 1ps

module drt_bounds
	import drt_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      mark,
	input  logic      take,
	input  drt_rect_t rect,
	output drt_box_t  box
);

	logic                  dirty_q;
	logic [BoundWidth-1:0] left_q;
	logic [BoundWidth-1:0] top_q;
	logic [BoundWidth-1:0] right_q;
	logic [BoundWidth-1:0] bottom_q;
	logic                  has;

	// Dirty box state: start or union on a kept mark, clear flag on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q <= 1'b0;
			left_q <= '0;
			top_q <= '0;
			right_q <= '0;
			bottom_q <= '0;
		end else if (take) begin
			dirty_q <= 1'b0;
		end else if (mark && rect.keep) begin
			dirty_q <= 1'b1;
			if (!dirty_q || rect.x < left_q) left_q <= rect.x;
			if (!dirty_q || rect.y < top_q) top_q <= rect.y;
			if (!dirty_q || rect.xe > right_q) right_q <= rect.xe;
			if (!dirty_q || rect.ye > bottom_q) bottom_q <= rect.ye;
		end
	end

	// Box seen by a take
	assign has = dirty_q && (left_q < right_q) && (top_q < bottom_q);

	always_comb begin
		box.has = has;
		box.x = has ? left_q[OrgWidth-1:0] : '0;
		box.y = has ? top_q[OrgWidth-1:0] : '0;
		box.w = has ? (right_q - left_q) : '0;
		box.h = has ? (bottom_q - top_q) : '0;
	end

endmodule

>>> sv/dirty_region_tracker.sv
`timescale 1ns / 1ps

// Dirty region tracker. Each req word either marks a rectangle dirty or takes
// the pending box. Marks that are empty or start off screen are dropped, the
// rest are clipped to the screen size and merged into the box by min/max union.
// A take returns one rsp word with the box (all zero when nothing is pending)
// and clears the pending state. One word is accepted every cycle unless the
// input stalls: a word is held in the input stage, where the clip and the four
// bound compares run, and a take's box then goes to the output register. Only
// a take blocked by a full output register not being read stalls the input.
// The user must write screen size through cfg while idle; the block does not check.
module dirty_region_tracker
	import drt_pkg::*;
#(
	parameter int COORD_WIDTH = DefCoordWidth
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CfgIdxWidth-1:0]  cfg_index,
	input  logic [CfgDataWidth-1:0] cfg_data,
	drt_req_if.sink                 req,
	drt_rsp_if.source               rsp
);

	logic [CfgDataWidth-1:0] screen_width_q;
	logic [CfgDataWidth-1:0] screen_height_q;

	logic                   valid_s1;
	logic                   action_s1;
	logic [COORD_WIDTH-1:0] rect_x_s1;
	logic [COORD_WIDTH-1:0] rect_y_s1;
	logic [COORD_WIDTH-1:0] rect_w_s1;
	logic [COORD_WIDTH-1:0] rect_h_s1;

	logic      adv_s1;
	logic      take;
	logic      mark;
	drt_rect_t rect;
	drt_box_t  box;

	logic     out_valid_q;
	drt_box_t out_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= ResetScreenWidth;
			screen_height_q <= ResetScreenHeight;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SCREEN_WIDTH: screen_width_q <= cfg_data;
				REG_SCREEN_HEIGHT: screen_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Stage 1 leaves when it holds a word, unless that word is a take and the output register is full and not being read
	assign adv_s1 = valid_s1 && (action_s1 == ACT_MARK || !out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign take = adv_s1 && (action_s1 == ACT_TAKE);
	assign mark = adv_s1 && (action_s1 == ACT_MARK);

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			action_s1 <= req.action;
			rect_x_s1 <= req.rect_x;
			rect_y_s1 <= req.rect_y;
			rect_w_s1 <= req.rect_w;
			rect_h_s1 <= req.rect_h;
		end
	end

	drt_clip #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_clip (
		.screen_width(screen_width_q),
		.screen_height(screen_height_q),
		.rect_x(rect_x_s1),
		.rect_y(rect_y_s1),
		.rect_w(rect_w_s1),
		.rect_h(rect_h_s1),
		.rect(rect)
	);

	drt_bounds u_bounds (
		.clk(clk),
		.arst_n(arst_n),
		.mark(mark),
		.take(take),
		.rect(rect),
		.box(box)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= box;
		end
	end

	assign rsp.valid = out_valid_q;
	assign rsp.has_region = out_q.has;
	assign rsp.box_x = out_q.x;
	assign rsp.box_y = out_q.y;
	assign rsp.box_w = out_q.w;
	assign rsp.box_h = out_q.h;

	// A take that leaves stage 1 always shows up on the response side
	a_take_out: assert property (@(posedge clk) disable iff (!arst_n)
		take |=> rsp.valid)
		else $error("take did not produce a response word");

	// A reported region is never degenerate
	a_region_size: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.has_region) |-> (rsp.box_w != '0 && rsp.box_h != '0))
		else $error("region reported with zero size");

	// No region means an all-zero box
	a_no_region: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.has_region) |->
			(rsp.box_x == '0 && rsp.box_y == '0 && rsp.box_w == '0 && rsp.box_h == '0))
		else $error("empty response carries a nonzero box");

	// A waiting response is never overwritten by another take
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.ready) |-> !take)
		else $error("response overwritten while stalled");

endmodule
